// ===== hw/rtl/pct_pkg.sv =====
package pct_pkg;

  // pair type codes carried in the kind field
  typedef enum logic [1:0] {
    KIND_BOX_BOX   = 2'd0,
    KIND_CIRC_CIRC = 2'd1,
    KIND_BOX_CIRC  = 2'd2
  } pct_kind_e;

  // per-pair decision flags passed down the pipeline
  typedef struct packed {
    logic box_ok;     // box or bounding-square test passed; always set for circle-circle
    logic need_dist;  // final answer depends on the distance compare
    logic strict;     // distance compare is strict (< instead of <=)
  } pct_flags_t;

endpackage

// ===== hw/rtl/primitive_collision_test_core.sv =====
// 2d overlap test between two primitive shapes: box-box, circle-circle or
// box against circle, one flag per pair.
// input: a word is taken at each rising edge where start_i is high and
// busy_o is low. busy_o stays low, so a new pair may be started every cycle.
// the word is kind_i plus centre and size of shapes a and b.
// output: done_o is high for exactly one cycle with hit_o valid in that
// cycle; the receiver cannot stall, so results are never held back.
// path: a word accepted at a rising edge passes four register stages (input,
// geometry, squares, compare) before its result shows on done_o/hit_o.
// throughput is one pair per cycle, set by the fully pipelined path with
// one multiplier stage.
// kind 3 gives a result with hit_o low.
// reset: rst_ni clears all stage valid bits; words in flight are dropped
// and no done_o strobe follows until a new word is started.
module primitive_collision_test_core import pct_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            kind_i,
  input  logic [COORD_BITS-1:0] a_x_i,
  input  logic [COORD_BITS-1:0] a_y_i,
  input  logic [COORD_BITS-2:0] a_w_i,
  input  logic [COORD_BITS-2:0] a_h_i,
  input  logic [COORD_BITS-1:0] b_x_i,
  input  logic [COORD_BITS-1:0] b_y_i,
  input  logic [COORD_BITS-2:0] b_w_i,
  input  logic [COORD_BITS-2:0] b_h_i,
  output logic                  done_o,
  output logic                  hit_o
);

  localparam int M = COORD_BITS + 2;

  logic accept;

  // input stage
  logic                  v0_q;
  logic [1:0]            kind_q;
  logic [COORD_BITS-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
  logic [COORD_BITS-2:0] a_w_q, a_h_q, b_w_q, b_h_q;

  // geometry stage
  pct_flags_t  flags_d, f1_q, f2_q;
  logic [M-1:0] mag_x_d, mag_y_d, mag_r_d, mag_x_q, mag_y_q, mag_r_q;
  logic v1_q, v2_q;

  // squares and compare
  logic [2*M-1:0] sq_x, sq_y, sq_r;
  logic [2*M:0]   dist_sum, rad_sq;
  logic           dist_ok;
  logic           hit_d, hit_q, done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      a_x_q  <= a_x_i;
      a_y_q  <= a_y_i;
      a_w_q  <= a_w_i;
      a_h_q  <= a_h_i;
      b_x_q  <= b_x_i;
      b_y_q  <= b_y_i;
      b_w_q  <= b_w_i;
      b_h_q  <= b_h_i;
    end
  end

  pct_prep #(
    .CoordBits(COORD_BITS)
  ) u_prep (
    .kind_i  (kind_q),
    .a_x_i   (a_x_q),
    .a_y_i   (a_y_q),
    .a_w_i   (a_w_q),
    .a_h_i   (a_h_q),
    .b_x_i   (b_x_q),
    .b_y_i   (b_y_q),
    .b_w_i   (b_w_q),
    .b_h_i   (b_h_q),
    .flags_o (flags_d),
    .mag_x_o (mag_x_d),
    .mag_y_o (mag_y_d),
    .mag_r_o (mag_r_d)
  );

  always_ff @(posedge clk_i) begin
    f1_q    <= flags_d;
    mag_x_q <= mag_x_d;
    mag_y_q <= mag_y_d;
    mag_r_q <= mag_r_d;
    f2_q    <= f1_q;
  end

  pct_square #(
    .MagBits(M)
  ) u_square (
    .clk_i   (clk_i),
    .mag_x_i (mag_x_q),
    .mag_y_i (mag_y_q),
    .mag_r_i (mag_r_q),
    .sq_x_o  (sq_x),
    .sq_y_o  (sq_y),
    .sq_r_o  (sq_r)
  );

  assign dist_sum = {1'b0, sq_x} + {1'b0, sq_y};
  assign rad_sq   = {1'b0, sq_r};
  assign dist_ok  = f2_q.strict ? (dist_sum < rad_sq) : (dist_sum <= rad_sq);
  assign hit_d    = f2_q.box_ok && (!f2_q.need_dist || dist_ok);

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= accept;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v0_q) else $error("accepted word did not enter the pipeline");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |=> done_o) else $error("missing result strobe");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v2_q |=> !done_o) else $error("result strobe without a word in flight");

  a_box_fail_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !f2_q.box_ok) |=> !hit_o) else $error("hit despite failed box test");

  a_box_only_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && f2_q.box_ok && !f2_q.need_dist) |=> hit_o)
    else $error("miss despite passed box test");

endmodule

// ===== hw/rtl/pct_prep.sv =====
module pct_prep import pct_pkg::*; #(
  parameter int CoordBits = 16
) (
  input  logic [1:0]             kind_i,
  input  logic [CoordBits-1:0]   a_x_i,
  input  logic [CoordBits-1:0]   a_y_i,
  input  logic [CoordBits-2:0]   a_w_i,
  input  logic [CoordBits-2:0]   a_h_i,
  input  logic [CoordBits-1:0]   b_x_i,
  input  logic [CoordBits-1:0]   b_y_i,
  input  logic [CoordBits-2:0]   b_w_i,
  input  logic [CoordBits-2:0]   b_h_i,
  output pct_flags_t             flags_o,
  output logic [CoordBits+1:0]   mag_x_o,
  output logic [CoordBits+1:0]   mag_y_o,
  output logic [CoordBits+1:0]   mag_r_o
);

  localparam int W = CoordBits + 3;  // signed working width
  localparam int M = CoordBits + 2;  // magnitude width

  logic signed [W-1:0] ax2, ay2, bx2, by2, aw, ah, bw, bh, r2;
  logic signed [W-1:0] ax, ay, bx, by;
  logic signed [W-1:0] a_r, a_l, a_t, a_b;
  logic signed [W-1:0] dx, dy, kdx, kdy;
  logic [W-1:0] abs_dx, abs_dy, abs_kdx, abs_kdy;
  logic box_hit, sq_hit, beyond_r, beyond_l, beyond_t, beyond_b;

  assign ax  = $signed({{3{a_x_i[CoordBits-1]}}, a_x_i});
  assign ay  = $signed({{3{a_y_i[CoordBits-1]}}, a_y_i});
  assign bx  = $signed({{3{b_x_i[CoordBits-1]}}, b_x_i});
  assign by  = $signed({{3{b_y_i[CoordBits-1]}}, b_y_i});
  assign ax2 = $signed({{2{a_x_i[CoordBits-1]}}, a_x_i, 1'b0});
  assign ay2 = $signed({{2{a_y_i[CoordBits-1]}}, a_y_i, 1'b0});
  assign bx2 = $signed({{2{b_x_i[CoordBits-1]}}, b_x_i, 1'b0});
  assign by2 = $signed({{2{b_y_i[CoordBits-1]}}, b_y_i, 1'b0});
  assign aw  = $signed({4'b0, a_w_i});
  assign ah  = $signed({4'b0, a_h_i});
  assign bw  = $signed({4'b0, b_w_i});
  assign bh  = $signed({4'b0, b_h_i});
  assign r2  = $signed({3'b0, b_w_i, 1'b0});

  // doubled edges of box a
  assign a_r = ax2 + aw;
  assign a_l = ax2 - aw;
  assign a_t = ay2 + ah;
  assign a_b = ay2 - ah;

  assign box_hit = (a_r > bx2 - bw) && (a_l < bx2 + bw) &&
                   (a_t > by2 - bh) && (a_b < by2 + bh);
  assign sq_hit  = (a_r > bx2 - r2) && (a_l < bx2 + r2) &&
                   (a_t > by2 - r2) && (a_b < by2 + r2);

  assign beyond_r = bx2 > a_r;
  assign beyond_l = bx2 < a_l;
  assign beyond_t = by2 > a_t;
  assign beyond_b = by2 < a_b;

  assign dx  = ax - bx;
  assign dy  = ay - by;
  assign kdx = (beyond_r ? a_r : a_l) - bx2;
  assign kdy = (beyond_t ? a_t : a_b) - by2;

  assign abs_dx  = dx[W-1]  ? -dx  : dx;
  assign abs_dy  = dy[W-1]  ? -dy  : dy;
  assign abs_kdx = kdx[W-1] ? -kdx : kdx;
  assign abs_kdy = kdy[W-1] ? -kdy : kdy;

  always_comb begin
    flags_o = '0;
    mag_x_o = '0;
    mag_y_o = '0;
    mag_r_o = '0;
    case (kind_i)
      KIND_BOX_BOX: begin
        flags_o.box_ok = box_hit;
      end
      KIND_CIRC_CIRC: begin
        flags_o.box_ok    = 1'b1;
        flags_o.need_dist = 1'b1;
        flags_o.strict    = 1'b1;
        mag_x_o = abs_dx[M-1:0];
        mag_y_o = abs_dy[M-1:0];
        mag_r_o = {3'b0, a_w_i} + {3'b0, b_w_i};
      end
      KIND_BOX_CIRC: begin
        // corner region only when the centre is off the box on both axes
        flags_o.box_ok    = sq_hit;
        flags_o.need_dist = (beyond_r || beyond_l) && (beyond_t || beyond_b);
        mag_x_o = abs_kdx[M-1:0];
        mag_y_o = abs_kdy[M-1:0];
        mag_r_o = {2'b0, b_w_i, 1'b0};
      end
      default: begin
        flags_o = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pct_square.sv =====
module pct_square #(
  parameter int MagBits = 18
) (
  input  logic                 clk_i,
  input  logic [MagBits-1:0]   mag_x_i,
  input  logic [MagBits-1:0]   mag_y_i,
  input  logic [MagBits-1:0]   mag_r_i,
  output logic [2*MagBits-1:0] sq_x_o,
  output logic [2*MagBits-1:0] sq_y_o,
  output logic [2*MagBits-1:0] sq_r_o
);

  logic [2*MagBits-1:0] sq_x_d, sq_y_d, sq_r_d;
  logic [2*MagBits-1:0] sq_x_q, sq_y_q, sq_r_q;

  assign sq_x_d = {{MagBits{1'b0}}, mag_x_i} * {{MagBits{1'b0}}, mag_x_i};
  assign sq_y_d = {{MagBits{1'b0}}, mag_y_i} * {{MagBits{1'b0}}, mag_y_i};
  assign sq_r_d = {{MagBits{1'b0}}, mag_r_i} * {{MagBits{1'b0}}, mag_r_i};

  always_ff @(posedge clk_i) begin
    sq_x_q <= sq_x_d;
    sq_y_q <= sq_y_d;
    sq_r_q <= sq_r_d;
  end

  assign sq_x_o = sq_x_q;
  assign sq_y_o = sq_y_q;
  assign sq_r_o = sq_r_q;

endmodule

// ===== sim/primitive_collision_test_core_test.sv =====
`timescale 1ns / 100ps

module primitive_collision_test_core_test import pct_pkg::*;;

  localparam int CW = 16;
  localparam int SW = CW - 1;
  localparam int DRAIN_CYCLES = 8;
  // kind code with no pair type, always answers no hit
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [1:0]    kind;
    logic [CW-1:0] ax, ay, bx, by;
    logic [CW-2:0] aw, ah, bw, bh;
  } shape_pair_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  logic          busy_o;
  logic [1:0]    kind_i;
  logic [CW-1:0] a_x_i, a_y_i, b_x_i, b_y_i;
  logic [CW-2:0] a_w_i, a_h_i, b_w_i, b_h_i;
  logic          done_o;
  logic          hit_o;

  bit hit_expect_q[$];
  int error_count;
  int result_count;
  int burst_left;
  bit idle_enabled;

  primitive_collision_test_core #(
    .COORD_BITS(CW)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .kind_i (kind_i),
    .a_x_i  (a_x_i),
    .a_y_i  (a_y_i),
    .a_w_i  (a_w_i),
    .a_h_i  (a_h_i),
    .b_x_i  (b_x_i),
    .b_y_i  (b_y_i),
    .b_w_i  (b_w_i),
    .b_h_i  (b_h_i),
    .done_o (done_o),
    .hit_o  (hit_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  // strict overlap of two boxes, centres doubled, sizes full
  function automatic bit boxes_meet(longint ax2, longint ay2, longint aw, longint ah,
                                    longint bx2, longint by2, longint bw, longint bh);
    return (ax2 + aw > bx2 - bw) && (ax2 - aw < bx2 + bw) &&
           (ay2 + ah > by2 - bh) && (ay2 - ah < by2 + bh);
  endfunction

  function automatic bit pair_hits(shape_pair_t p);
    longint ax2, ay2, bx2, by2, aw, ah, bw, bh, dx, dy, kx, ky;
    ax2 = 2 * longint'($signed(p.ax));
    ay2 = 2 * longint'($signed(p.ay));
    bx2 = 2 * longint'($signed(p.bx));
    by2 = 2 * longint'($signed(p.by));
    aw = longint'(p.aw);
    ah = longint'(p.ah);
    bw = longint'(p.bw);
    bh = longint'(p.bh);
    case (p.kind)
      KIND_BOX_BOX: return boxes_meet(ax2, ay2, aw, ah, bx2, by2, bw, bh);
      KIND_CIRC_CIRC: begin
        // both sides doubled: (2d)^2 < (2(ra+rb))^2
        dx = ax2 - bx2;
        dy = ay2 - by2;
        return dx * dx + dy * dy < 4 * (aw + bw) * (aw + bw);
      end
      KIND_BOX_CIRC: begin
        if (!boxes_meet(ax2, ay2, aw, ah, bx2, by2, 2 * bw, 2 * bw)) return 1'b0;
        if (bx2 > ax2 + aw) kx = ax2 + aw;
        else if (bx2 < ax2 - aw) kx = ax2 - aw;
        else return 1'b1;
        if (by2 > ay2 + ah) ky = ay2 + ah;
        else if (by2 < ay2 - ah) ky = ay2 - ah;
        else return 1'b1;
        // centre beyond a corner: corner distance at most the radius
        dx = kx - bx2;
        dy = ky - by2;
        return dx * dx + dy * dy <= 4 * bw * bw;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic shape_pair_t make_pair(logic [1:0] kind, int ax, int ay, int aw, int ah,
                                            int bx, int by, int bw, int bh);
    shape_pair_t p;
    p.kind = kind;
    p.ax = CW'(ax);
    p.ay = CW'(ay);
    p.aw = SW'(aw);
    p.ah = SW'(ah);
    p.bx = CW'(bx);
    p.by = CW'(by);
    p.bw = SW'(bw);
    p.bh = SW'(bh);
    return p;
  endfunction

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_pair(input shape_pair_t p);
    int gap;
    if (idle_enabled && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    start_i <= 1'b1;
    kind_i <= p.kind;
    a_x_i <= p.ax;
    a_y_i <= p.ay;
    a_w_i <= p.aw;
    a_h_i <= p.ah;
    b_x_i <= p.bx;
    b_y_i <= p.by;
    b_w_i <= p.bw;
    b_h_i <= p.bh;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    hit_expect_q = {hit_expect_q, pair_hits(p)};
  endtask

  // hold off until every pending result has come back
  task automatic drain_results();
    start_i <= 1'b0;
    while (hit_expect_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      result_count++;
      if (hit_expect_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", result_count));
      end else begin
        if (hit_o !== hit_expect_q[0])
          report_mismatch($sformatf("result %0d: hit %b, predicted %b",
                                    result_count, hit_o, hit_expect_q[0]));
        void'(hit_expect_q.pop_front());
      end
    end
  end

  task automatic test_box_pairs();
    send_pair(make_pair(KIND_BOX_BOX, 0, 0, 32, 32, 16, 16, 32, 32));
    // edges touching is not an overlap
    send_pair(make_pair(KIND_BOX_BOX, 0, 0, 32, 32, 32, 0, 32, 32));
    send_pair(make_pair(KIND_BOX_BOX, 5, 5, 0, 0, 5, 5, 0, 0));
    // zero size box inside a bigger one
    send_pair(make_pair(KIND_BOX_BOX, 5, 5, 0, 0, 0, 0, 40, 40));
  endtask

  task automatic test_circle_pairs();
    send_pair(make_pair(KIND_CIRC_CIRC, 0, 0, 10, 0, 20, 0, 10, 0));
    send_pair(make_pair(KIND_CIRC_CIRC, 0, 0, 10, 7, 19, 0, 10, 3));
    send_pair(make_pair(KIND_CIRC_CIRC, -3, 4, 0, 0, -3, 4, 0, 0));
  endtask

  task automatic test_box_circle_pairs();
    // corner region inside the radius
    send_pair(make_pair(KIND_BOX_CIRC, 0, 0, 20, 20, 17, 17, 10, 0));
    // bounding square passes, corner distance too far
    send_pair(make_pair(KIND_BOX_CIRC, 0, 0, 20, 20, 18, 18, 10, 0));
    // corner distance exactly equal to the radius
    send_pair(make_pair(KIND_BOX_CIRC, 0, 0, 20, 20, 16, 18, 10, 0));
    send_pair(make_pair(KIND_BOX_CIRC, 0, 0, 20, 20, -16, -18, 10, 0));
    // beside an edge, within and outside
    send_pair(make_pair(KIND_BOX_CIRC, 0, 0, 20, 20, 19, 0, 10, 5));
    send_pair(make_pair(KIND_BOX_CIRC, 0, 0, 20, 20, 25, 0, 10, 5));
  endtask

  task automatic test_unused_kind();
    send_pair(make_pair(KIND_NONE, 0, 0, 32, 32, 0, 0, 32, 32));
    send_pair(make_pair(KIND_NONE, 1, 1, 0, 0, 1, 1, 0, 0));
  endtask

  task automatic test_extremes();
    for (int k = 0; k < 4; k++) begin
      send_pair(make_pair(2'(k), -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
      send_pair(make_pair(2'(k), 32767, 32767, 0, 0, -32768, -32768, 0, 0));
    end
  endtask

  function automatic int corner_value(bit is_coord);
    case ($urandom_range(0, 3))
      0: return is_coord ? -32768 : 0;
      1: return is_coord ? 32767 : 32767;
      2: return is_coord ? -1 : 1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    int scale, span, style;
    p.kind = ($urandom_range(0, 11) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
    style = $urandom_range(0, 9);
    if (style < 2) begin
      p.ax = CW'($urandom);
      p.ay = CW'($urandom);
      p.bx = CW'($urandom);
      p.by = CW'($urandom);
      p.aw = SW'($urandom);
      p.ah = SW'($urandom);
      p.bw = SW'($urandom);
      p.bh = SW'($urandom);
    end else if (style < 9) begin
      // shapes near each other so that hits and misses both occur
      scale = $urandom_range(2, 14);
      span = 1 << scale;
      p.ax = CW'($urandom);
      p.ay = CW'($urandom);
      p.bx = CW'(int'(p.ax) + int'($urandom_range(0, 2 * span)) - span);
      p.by = CW'(int'(p.ay) + int'($urandom_range(0, 2 * span)) - span);
      p.aw = SW'($urandom_range(0, span - 1));
      p.ah = SW'($urandom_range(0, span - 1));
      p.bw = SW'($urandom_range(0, span - 1));
      p.bh = SW'($urandom_range(0, span - 1));
    end else begin
      p.ax = CW'(corner_value(1'b1));
      p.ay = CW'(corner_value(1'b1));
      p.bx = CW'(corner_value(1'b1));
      p.by = CW'(corner_value(1'b1));
      p.aw = SW'(corner_value(1'b0));
      p.ah = SW'(corner_value(1'b0));
      p.bw = SW'(corner_value(1'b0));
      p.bh = SW'(corner_value(1'b0));
    end
    return p;
  endfunction

  task automatic test_random_pairs();
    idle_enabled = 1'b1;
    repeat (500) send_pair(random_pair());
    idle_enabled = 1'b0;
    repeat (150) send_pair(random_pair());
    drain_results();
    idle_enabled = 1'b1;
    burst_left = 0;
    repeat (477) send_pair(random_pair());
  endtask

  initial begin
    error_count = 0;
    result_count = 0;
    burst_left = 0;
    idle_enabled = 1'b1;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    kind_i <= '0;
    a_x_i <= '0;
    a_y_i <= '0;
    a_w_i <= '0;
    a_h_i <= '0;
    b_x_i <= '0;
    b_y_i <= '0;
    b_w_i <= '0;
    b_h_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_box_pairs();
    test_circle_pairs();
    test_box_circle_pairs();
    test_unused_kind();
    test_extremes();
    drain_results();
    test_random_pairs();
    drain_results();

    if (error_count == 0 && hit_expect_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
